// File: hdl/tlb_pkg.sv
// ----------------------------------------------------------------------------
// tlb_pkg
// shared types and constants for the triphone tree lookup with backoff
// ----------------------------------------------------------------------------
`default_nettype none

package tlb_pkg;

    localparam int WORD_POSITIONS = 4;

    localparam logic [1:0] OP_NODE_WR  = 2'd0;
    localparam logic [1:0] OP_FLAG_WR  = 2'd1;
    localparam logic [1:0] OP_EXACT    = 2'd2;
    localparam logic [1:0] OP_NEAREST  = 2'd3;

    localparam logic [2:0] POS_BEGIN   = 3'd1;
    localparam logic [2:0] POS_END     = 3'd2;
    localparam logic [2:0] POS_SINGLE  = 3'd3;

    localparam logic REG_SILENCE = 1'b0;
    localparam logic REG_TREE    = 1'b1;

    localparam logic signed [20:0] NO_MATCH = -21'sd1;

    typedef struct packed {
        logic [7:0]         ctx;
        logic [7:0]         children;
        logic signed [20:0] link;
    } node_t;

    typedef struct packed {
        logic signed [8:0] silence_phone;
        logic              tree_present;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FL,
        ST_FR,
        ST_FS,
        ST_FD,
        ST_ATT,
        ST_SCAN,
        ST_CHK,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// File: hdl/tlb_item_if.sv
// ----------------------------------------------------------------------------
// tlb_item_if
// input channel: write or lookup transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface tlb_item_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [12:0]       node_index;
    logic [7:0]        node_context;
    logic [7:0]        node_children;
    logic signed [20:0] node_link;
    logic              filler_flag;
    logic [7:0]        base_phone;
    logic signed [8:0] left_phone;
    logic signed [8:0] right_phone;
    logic [2:0]        word_position;

    modport source (
        output valid, opcode, node_index, node_context, node_children, node_link,
               filler_flag, base_phone, left_phone, right_phone, word_position,
        input  ready
    );
    modport sink (
        input  valid, opcode, node_index, node_context, node_children, node_link,
               filler_flag, base_phone, left_phone, right_phone, word_position,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/tlb_result_if.sv
// ----------------------------------------------------------------------------
// tlb_result_if
// output channel: lookup result transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface tlb_result_if;
    logic               valid;
    logic               ready;
    logic signed [20:0] phone_id;

    modport source (output valid, phone_id, input ready);
    modport sink (input valid, phone_id, output ready);
endinterface

`default_nettype wire

// File: hdl/tlb_ram.sv
// ----------------------------------------------------------------------------
// tlb_ram
// generic simple dual-port ram, one write port, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

// File: hdl/tlb_engine.sv
// ----------------------------------------------------------------------------
// tlb_engine
// lookup sequencer: filler flag reads, backoff attempts and tree level scans
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_engine #(
    parameter int TREE_NODES = 8192,
    parameter int PHONES     = 256
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tlb_pkg::cfg_t cfg,
    tlb_item_if.sink           in_ch,
    tlb_result_if.source       out_ch
);
    localparam int TN_AW = (TREE_NODES > 1) ? $clog2(TREE_NODES) : 1;
    localparam int PH_AW = (PHONES > 1) ? $clog2(PHONES) : 1;

    tlb_pkg::state_t st_reg, st_next;

    logic               near_reg, near_next;
    logic [7:0]         b_reg, b_next;
    logic signed [8:0]  l_reg, l_next, r_reg, r_next;
    logic [2:0]         pos_reg, pos_next;
    logic               fl_reg, fl_next, fr_reg, fr_next, fs_reg, fs_next;
    logic               round_reg, round_next;
    logic [2:0]         att_reg, att_next;
    logic [7:0]         cl_reg, cl_next, cr_reg, cr_next;
    logic [7:0]         wl_reg, wl_next, wr_reg, wr_next;
    logic [1:0]         tpos_reg, tpos_next;
    logic [1:0]         lvl_reg, lvl_next;
    logic [20:0]        base_reg, base_next;
    logic [7:0]         cnt_reg, cnt_next;
    logic [8:0]         i_reg, i_next;
    logic signed [20:0] res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [20:0] out_id_reg, out_id_next;

    logic               tree_we, flag_we;
    logic [TN_AW-1:0]   tree_waddr, tree_raddr;
    logic [PH_AW-1:0]   flag_raddr;
    tlb_pkg::node_t     tree_wdata, node;
    logic               flag_rdata;

    logic               accept;
    logic [2:0]         t_pos;
    logic [7:0]         nl, nr, want;
    logic [20:0]        scan_addr;
    logic               cur_fl, cur_fr;

    tlb_ram #(.WIDTH($bits(tlb_pkg::node_t)), .DEPTH(TREE_NODES)) u_tree (
        .clk   (clk),
        .we    (tree_we),
        .waddr (tree_waddr),
        .wdata (tree_wdata),
        .raddr (tree_raddr),
        .rdata (node)
    );

    tlb_ram #(.WIDTH(1), .DEPTH(PHONES)) u_flags (
        .clk   (clk),
        .we    (flag_we),
        .waddr (in_ch.base_phone[PH_AW-1:0]),
        .wdata (in_ch.filler_flag),
        .raddr (flag_raddr),
        .rdata (flag_rdata)
    );

    function automatic logic in_range(input logic signed [8:0] p);
        in_range = !p[8] && (32'(p[7:0]) < PHONES);
    endfunction

    assign in_ch.ready     = (st_reg == tlb_pkg::ST_IDLE);
    assign accept          = in_ch.valid && in_ch.ready;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.phone_id = out_id_reg;

    assign tree_we    = accept && (in_ch.opcode == tlb_pkg::OP_NODE_WR)
                        && (32'(in_ch.node_index) < TREE_NODES);
    assign tree_waddr = TN_AW'(in_ch.node_index);
    assign tree_wdata = '{ctx: in_ch.node_context, children: in_ch.node_children,
                          link: in_ch.node_link};
    assign flag_we    = accept && (in_ch.opcode == tlb_pkg::OP_FLAG_WR)
                        && (32'(in_ch.base_phone) < PHONES);

    assign t_pos     = (att_reg == 3'd0) ? pos_reg : (att_reg - 3'd1);
    assign nl        = (fl_reg || pos_reg == tlb_pkg::POS_BEGIN || pos_reg == tlb_pkg::POS_SINGLE)
                       ? cfg.silence_phone[7:0] : l_reg[7:0];
    assign nr        = (fr_reg || pos_reg == tlb_pkg::POS_END || pos_reg == tlb_pkg::POS_SINGLE)
                       ? cfg.silence_phone[7:0] : r_reg[7:0];
    assign cur_fl    = (cl_reg == l_reg[7:0]) ? fl_reg : fs_reg;
    assign cur_fr    = (cr_reg == r_reg[7:0]) ? fr_reg : fs_reg;
    assign scan_addr = base_reg + 21'(i_reg);
    assign tree_raddr = scan_addr[TN_AW-1:0];

    always_comb
    begin
        case (lvl_reg)
            2'd0:    want = {6'd0, tpos_reg};
            2'd1:    want = b_reg;
            2'd2:    want = wl_reg;
            default: want = wr_reg;
        endcase
    end

    always_comb
    begin
        case (st_reg)
            tlb_pkg::ST_FL: flag_raddr = l_reg[PH_AW-1:0];
            tlb_pkg::ST_FR: flag_raddr = r_reg[PH_AW-1:0];
            default:        flag_raddr = cfg.silence_phone[PH_AW-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= tlb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        near_reg  <= near_next;
        b_reg     <= b_next;
        l_reg     <= l_next;
        r_reg     <= r_next;
        pos_reg   <= pos_next;
        fl_reg    <= fl_next;
        fr_reg    <= fr_next;
        fs_reg    <= fs_next;
        round_reg <= round_next;
        att_reg   <= att_next;
        cl_reg    <= cl_next;
        cr_reg    <= cr_next;
        wl_reg    <= wl_next;
        wr_reg    <= wr_next;
        tpos_reg  <= tpos_next;
        lvl_reg   <= lvl_next;
        base_reg  <= base_next;
        cnt_reg   <= cnt_next;
        i_reg     <= i_next;
        res_reg   <= res_next;
        out_id_reg <= out_id_next;
    end

    always_comb
    begin
        st_next    = st_reg;
        near_next  = near_reg;
        b_next     = b_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        pos_next   = pos_reg;
        fl_next    = fl_reg;
        fr_next    = fr_reg;
        fs_next    = fs_reg;
        round_next = round_reg;
        att_next   = att_reg;
        cl_next    = cl_reg;
        cr_next    = cr_reg;
        wl_next    = wl_reg;
        wr_next    = wr_reg;
        tpos_next  = tpos_reg;
        lvl_next   = lvl_reg;
        base_next  = base_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        res_next   = res_reg;
        out_id_next = out_id_reg;
        out_valid_next = out_ch.ready ? 1'b0 : out_valid_reg;

        case (st_reg)
            tlb_pkg::ST_IDLE:
            begin
                if (accept && (in_ch.opcode == tlb_pkg::OP_EXACT
                               || in_ch.opcode == tlb_pkg::OP_NEAREST))
                begin
                    near_next = (in_ch.opcode == tlb_pkg::OP_NEAREST);
                    b_next    = in_ch.base_phone;
                    l_next    = in_ch.left_phone;
                    r_next    = in_ch.right_phone;
                    pos_next  = in_ch.word_position;
                    st_next   = tlb_pkg::ST_FL;
                end
            end
            tlb_pkg::ST_FL:
            begin
                st_next = tlb_pkg::ST_FR;
            end
            tlb_pkg::ST_FR:
            begin
                fl_next = flag_rdata && in_range(l_reg);
                st_next = tlb_pkg::ST_FS;
            end
            tlb_pkg::ST_FS:
            begin
                fr_next = flag_rdata && in_range(r_reg);
                st_next = tlb_pkg::ST_FD;
            end
            tlb_pkg::ST_FD:
            begin
                fs_next    = flag_rdata && in_range(cfg.silence_phone);
                att_next   = 3'd0;
                round_next = 1'b0;
                cl_next    = l_reg[7:0];
                cr_next    = r_reg[7:0];
                st_next    = tlb_pkg::ST_ATT;
                if (near_reg)
                begin
                    if (l_reg[8] || r_reg[8])
                    begin
                        res_next = 21'(b_reg);
                        st_next  = tlb_pkg::ST_OUT;
                    end
                end
                else if (l_reg[8] && r_reg[8] && pos_reg[2])
                begin
                    res_next = 21'(b_reg);
                    st_next  = tlb_pkg::ST_OUT;
                end
                else if (!cfg.tree_present || l_reg[8] || r_reg[8] || pos_reg[2])
                begin
                    res_next = tlb_pkg::NO_MATCH;
                    st_next  = tlb_pkg::ST_OUT;
                end
            end
            tlb_pkg::ST_ATT:
            begin
                if (att_reg == 3'd5)
                begin
                    if (!round_reg && !cfg.silence_phone[8]
                        && (nl != l_reg[7:0] || nr != r_reg[7:0]))
                    begin
                        round_next = 1'b1;
                        att_next   = 3'd0;
                        cl_next    = nl;
                        cr_next    = nr;
                    end
                    else
                    begin
                        res_next = 21'(b_reg);
                        st_next  = tlb_pkg::ST_OUT;
                    end
                end
                else if ((att_reg != 3'd0 && t_pos == pos_reg)
                         || t_pos[2] || !cfg.tree_present)
                begin
                    att_next = att_reg + 3'd1;
                end
                else
                begin
                    wl_next   = (!cfg.silence_phone[8] && cur_fl)
                                ? cfg.silence_phone[7:0] : cl_reg;
                    wr_next   = (!cfg.silence_phone[8] && cur_fr)
                                ? cfg.silence_phone[7:0] : cr_reg;
                    tpos_next = t_pos[1:0];
                    lvl_next  = 2'd0;
                    base_next = 21'd0;
                    cnt_next  = 8'(tlb_pkg::WORD_POSITIONS);
                    i_next    = 9'd0;
                    st_next   = tlb_pkg::ST_SCAN;
                end
            end
            tlb_pkg::ST_SCAN:
            begin
                if (i_reg >= {1'b0, cnt_reg} || 32'(scan_addr) >= TREE_NODES)
                begin
                    if (near_reg)
                    begin
                        att_next = att_reg + 3'd1;
                        st_next  = tlb_pkg::ST_ATT;
                    end
                    else
                    begin
                        res_next = tlb_pkg::NO_MATCH;
                        st_next  = tlb_pkg::ST_OUT;
                    end
                end
                else
                begin
                    st_next = tlb_pkg::ST_CHK;
                end
            end
            tlb_pkg::ST_CHK:
            begin
                if (node.ctx != want)
                begin
                    i_next  = i_reg + 9'd1;
                    st_next = tlb_pkg::ST_SCAN;
                end
                else if (node.children == 8'd0 && (!near_reg || !node.link[20]))
                begin
                    res_next = node.link;
                    st_next  = tlb_pkg::ST_OUT;
                end
                else if (node.children == 8'd0 || node.link[20] || lvl_reg == 2'd3)
                begin
                    if (near_reg)
                    begin
                        att_next = att_reg + 3'd1;
                        st_next  = tlb_pkg::ST_ATT;
                    end
                    else
                    begin
                        res_next = tlb_pkg::NO_MATCH;
                        st_next  = tlb_pkg::ST_OUT;
                    end
                end
                else
                begin
                    base_next = node.link;
                    cnt_next  = node.children;
                    i_next    = 9'd0;
                    lvl_next  = lvl_reg + 2'd1;
                    st_next   = tlb_pkg::ST_SCAN;
                end
            end
            tlb_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = res_reg;
                    st_next        = tlb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                st_next = tlb_pkg::ST_IDLE;
            end
        endcase
    end

    // node check always comes in the cycle right after the address issue
    a_chk_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == tlb_pkg::ST_CHK |-> $past(st_reg == tlb_pkg::ST_SCAN))
        else $error("node check without a preceding read");

    a_att_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == tlb_pkg::ST_SCAN || st_reg == tlb_pkg::ST_CHK) |-> att_reg <= 3'd4)
        else $error("attempt counter out of range during scan");

    a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_ch.opcode == tlb_pkg::OP_NODE_WR || in_ch.opcode == tlb_pkg::OP_FLAG_WR)
        |=> st_reg == tlb_pkg::ST_IDLE)
        else $error("write transaction left idle");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(st_reg == tlb_pkg::ST_OUT))
        else $error("result raised outside the output state");

endmodule

`default_nettype wire

// File: hdl/triphone_tree_lookup_backoff_core.sv
// operation: a write is taken in the idle state; a lookup reads the left, right and silence
// filler flags, then runs backoff attempts of tree node reads and loads the result register
// throughput: one transaction at a time, data dependent, up to 8 backoff attempts of
// 4 levels of up to 255 node reads each, set by the single read port of the tree ram
// reset: asynchronous active low, silence_phone = -1, tree_present = 0; ram contents
// are undefined until written
// ----------------------------------------------------------------------------
// triphone_tree_lookup_backoff_core
// context tree phone lookup with backoff, apb configuration port
// ----------------------------------------------------------------------------
`default_nettype none

module triphone_tree_lookup_backoff_core #(
    parameter int TREE_NODES = 8192,
    parameter int PHONES     = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    tlb_item_if.sink         in_ch,
    tlb_result_if.source     out_ch
);
    logic signed [8:0] sil_reg;
    logic              tp_reg;
    tlb_pkg::cfg_t     cfg;

    assign pready = 1'b1;
    assign cfg    = '{silence_phone: sil_reg, tree_present: tp_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sil_reg <= -9'sd1;
            tp_reg  <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == tlb_pkg::REG_SILENCE)
            begin
                sil_reg <= pwdata[8:0];
            end
            else
            begin
                tp_reg <= pwdata[0];
            end
        end
    end

    always_comb
    begin
        case (paddr[2])
            tlb_pkg::REG_SILENCE: prdata = {{23{sil_reg[8]}}, sil_reg};
            default:              prdata = {31'd0, tp_reg};
        endcase
    end

    tlb_engine #(.TREE_NODES(TREE_NODES), .PHONES(PHONES)) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );
endmodule

`default_nettype wire
